@@ rtl/cdt_pkg.sv @@
package cdt_pkg;

    localparam int ID_W     = 7;
    localparam int OWNER_W  = 16;
    localparam int TYPE_W   = 4;
    localparam int RIGHTS_W = 32;
    localparam int COUNT_W  = 7;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_DERIVE   = 2'd1,
        OP_REVOKE   = 2'd2,
        OP_QUERY    = 2'd3
    } cdt_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NO_PARENT = 2'd2,
        ST_ESCALATE  = 2'd3
    } cdt_status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic do_reg;
        logic drv_check;
        logic do_drv;
        logic rvk_mark;
        logic scan_start;
        logic scan;
        logic finish;
    } cdt_cmd_t;

    // datapath to controller
    typedef struct packed {
        cdt_op_t op;
        logic    parent_ok;
        logic    scan_done;
    } cdt_sts_t;

endpackage

@@ rtl/cdt_ram.sv @@
module cdt_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 64
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/cdt_ctrl.sv @@
module cdt_ctrl
    import cdt_pkg::*;
    (
        input  logic     clk,
        input  logic     rst_n,
        input  logic     start,
        output logic     busy,
        input  cdt_sts_t sts,
        output cdt_cmd_t cmd
    );

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_DISPATCH = 4'b0010,
        S_DRV_EXEC = 4'b0100,
        S_SCAN     = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.op)
                    OP_REGISTER:
                    begin
                        cmd.do_reg = 1'b1;
                        state_next = S_IDLE;
                    end
                    OP_DERIVE:
                    begin
                        cmd.drv_check = 1'b1;
                        state_next    = sts.parent_ok ? S_DRV_EXEC : S_IDLE;
                    end
                    OP_REVOKE:
                    begin
                        cmd.rvk_mark   = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    OP_QUERY:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DRV_EXEC:
            begin
                cmd.do_drv = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ rtl/cdt_dp.sv @@
module cdt_dp
    import cdt_pkg::*;
    #(
        parameter int ENTRIES = 64
    )
    (
        input  logic                clk,
        input  logic                rst_n,
        input  cdt_cmd_t            cmd,
        output cdt_sts_t            sts,
        input  logic [1:0]          op,
        input  logic [OWNER_W-1:0]  owner,
        input  logic [TYPE_W-1:0]   cap_type,
        input  logic [RIGHTS_W-1:0] rights,
        input  logic [ID_W-1:0]     target_id,
        output logic                result_valid,
        output logic [1:0]          status,
        output logic [ID_W-1:0]     cap_id,
        output logic [COUNT_W-1:0]  revoked_count,
        output logic                match_valid,
        output logic                last
    );

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    // latched item
    cdt_op_t             op_reg;
    logic [OWNER_W-1:0]  owner_reg;
    logic [TYPE_W-1:0]   cap_type_reg;
    logic [RIGHTS_W-1:0] rights_reg;
    logic [ID_W-1:0]     tid_reg;

    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;

    // scan pipeline
    logic [CW-1:0]      idx_reg;
    logic               s1_valid_reg;
    logic [AW-1:0]      s1_idx_reg;
    logic               s2_valid_reg;
    logic [AW-1:0]      s2_idx_reg;
    logic [AW-1:0]      s2_pidx_reg;
    logic               wr_hit_reg;
    logic [AW-1:0]      wr_idx_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               pend_valid_reg;
    logic [ID_W-1:0]    pend_id_reg;

    // result registers
    logic               res_valid_reg;
    logic               res_valid_next;
    cdt_status_t        res_status_reg;
    cdt_status_t        res_status_next;
    logic [ID_W-1:0]    res_id_reg;
    logic [ID_W-1:0]    res_id_next;
    logic [COUNT_W-1:0] res_count_reg;
    logic [COUNT_W-1:0] res_count_next;
    logic               res_mv_reg;
    logic               res_mv_next;
    logic               res_last_reg;
    logic               res_last_next;

    // memory ports
    logic [ID_W-1:0]     parent_q;
    logic [OWNER_W-1:0]  owner_q;
    logic [TYPE_W-1:0]   type_q;
    logic [RIGHTS_W-1:0] rights_q;
    logic                reva_q;
    logic                revb_q;

    logic                tbl_we;
    logic [ID_W-1:0]     tbl_parent;
    logic [TYPE_W-1:0]   tbl_type;
    logic                rev_we;
    logic [AW-1:0]       rev_waddr;
    logic                rev_wdata;

    logic [ID_W-1:0] fill_id;
    logic [ID_W-1:0] tid_dec;
    logic [ID_W-1:0] parent_dec;
    logic            target_ok;
    logic            is_full;
    logic            escalate;
    logic            drv_ok;
    logic            issue;
    logic            s1_cand;
    logic            query_hit;
    logic            scan_mark;

    assign fill_id    = ID_W'(fill_reg);
    assign tid_dec    = tid_reg - ID_W'(1);
    assign parent_dec = parent_q - ID_W'(1);
    assign target_ok  = (tid_reg != '0) && (tid_reg <= fill_id);
    assign is_full    = (fill_reg == FULL);
    assign escalate   = ((rights_reg & rights_q) != rights_reg);
    assign drv_ok     = !escalate && !is_full;

    assign issue     = cmd.scan && (idx_reg < fill_reg);
    assign s1_cand   = s1_valid_reg && (op_reg == OP_REVOKE) && !reva_q
                       && (parent_q != '0) && (parent_q <= fill_id);
    assign query_hit = s1_valid_reg && (op_reg == OP_QUERY) && !reva_q
                       && (owner_q == owner_reg);
    // a parent marked by the entry just before was written at the same edge as
    // the read, so take it from the forward register
    assign scan_mark = s2_valid_reg
                       && (revb_q || (wr_hit_reg && (wr_idx_reg == s2_pidx_reg)));

    assign sts.op        = op_reg;
    assign sts.parent_ok = target_ok;
    assign sts.scan_done = (idx_reg == fill_reg) && !s1_valid_reg && !s2_valid_reg;

    // write port selection
    assign tbl_we     = (cmd.do_reg && !is_full) || (cmd.do_drv && drv_ok);
    assign tbl_parent = cmd.do_reg ? '0 : tid_reg;
    assign tbl_type   = cmd.do_reg ? cap_type_reg : type_q;

    always_comb
    begin
        rev_we    = 1'b0;
        rev_waddr = fill_reg[AW-1:0];
        rev_wdata = 1'b0;
        priority if (tbl_we)
        begin
            rev_we = 1'b1;
        end
        else if (cmd.rvk_mark && target_ok)
        begin
            rev_we    = 1'b1;
            rev_waddr = tid_dec[AW-1:0];
            rev_wdata = 1'b1;
        end
        else if (scan_mark)
        begin
            rev_we    = 1'b1;
            rev_waddr = s2_idx_reg;
            rev_wdata = 1'b1;
        end
    end

    cdt_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_parent (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (tbl_parent),
        .raddr (idx_reg[AW-1:0]),
        .rdata (parent_q)
    );

    cdt_ram #(.WIDTH(OWNER_W), .DEPTH(ENTRIES)) u_owner (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (owner_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (owner_q)
    );

    cdt_ram #(.WIDTH(TYPE_W), .DEPTH(ENTRIES)) u_type (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (tbl_type),
        .raddr (tid_dec[AW-1:0]),
        .rdata (type_q)
    );

    cdt_ram #(.WIDTH(RIGHTS_W), .DEPTH(ENTRIES)) u_rights (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (rights_reg),
        .raddr (tid_dec[AW-1:0]),
        .rdata (rights_q)
    );

    // two copies of the revoked flags: one read at the scanned entry, one at its parent
    cdt_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_rev_a (
        .clk   (clk),
        .we    (rev_we),
        .waddr (rev_waddr),
        .wdata (rev_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (reva_q)
    );

    cdt_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_rev_b (
        .clk   (clk),
        .we    (rev_we),
        .waddr (rev_waddr),
        .wdata (rev_wdata),
        .raddr (parent_dec[AW-1:0]),
        .rdata (revb_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= cdt_op_t'(op);
            owner_reg    <= owner;
            cap_type_reg <= cap_type;
            rights_reg   <= rights;
            tid_reg      <= target_id;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (tbl_we)
        begin
            fill_next = fill_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            idx_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            wr_hit_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            s1_valid_reg  <= issue;
            s2_valid_reg  <= cmd.scan && s1_cand;
            wr_hit_reg    <= scan_mark;
            res_valid_reg <= res_valid_next;
            if (cmd.scan_start)
            begin
                idx_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
                if (query_hit)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= idx_reg[AW-1:0];
        s2_idx_reg  <= s1_idx_reg;
        s2_pidx_reg <= parent_dec[AW-1:0];
        wr_idx_reg  <= s2_idx_reg;
        if (query_hit)
        begin
            pend_id_reg <= ID_W'(s1_idx_reg) + ID_W'(1);
        end
        if (cmd.rvk_mark)
        begin
            count_reg <= target_ok ? COUNT_W'(1) : '0;
        end
        else if (scan_mark)
        begin
            count_reg <= count_reg + COUNT_W'(1);
        end
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_count_reg  <= res_count_next;
        res_mv_reg     <= res_mv_next;
        res_last_reg   <= res_last_next;
    end

    always_comb
    begin
        res_valid_next  = 1'b0;
        res_status_next = ST_OK;
        res_id_next     = '0;
        res_count_next  = '0;
        res_mv_next     = 1'b0;
        res_last_next   = 1'b1;
        priority if (cmd.do_reg)
        begin
            res_valid_next = 1'b1;
            if (is_full)
            begin
                res_status_next = ST_FULL;
            end
            else
            begin
                res_id_next = fill_id + ID_W'(1);
            end
        end
        else if (cmd.drv_check && !target_ok)
        begin
            res_valid_next  = 1'b1;
            res_status_next = ST_NO_PARENT;
        end
        else if (cmd.do_drv)
        begin
            res_valid_next = 1'b1;
            priority if (escalate)
            begin
                res_status_next = ST_ESCALATE;
            end
            else if (is_full)
            begin
                res_status_next = ST_FULL;
            end
            else
            begin
                res_id_next = fill_id + ID_W'(1);
            end
        end
        else if (query_hit && pend_valid_reg)
        begin
            // a newer match exists, so the held one is not the final result
            res_valid_next = 1'b1;
            res_id_next    = pend_id_reg;
            res_mv_next    = 1'b1;
            res_last_next  = 1'b0;
        end
        else if (cmd.finish)
        begin
            res_valid_next = 1'b1;
            if (op_reg == OP_REVOKE)
            begin
                res_count_next = count_reg;
            end
            else if (pend_valid_reg)
            begin
                res_id_next = pend_id_reg;
                res_mv_next = 1'b1;
            end
        end
    end

    assign result_valid  = res_valid_reg;
    assign status        = res_status_reg;
    assign cap_id        = res_id_reg;
    assign revoked_count = res_count_reg;
    assign match_valid   = res_mv_reg;
    assign last          = res_last_reg;

endmodule

@@ rtl/capability_derivation_table.sv @@
// Capability derivation table: append-only store of up to ENTRIES capabilities.
// Command channel: an item (op, owner, cap_type, rights, target_id) transfers on
// a rising edge with start high and busy low. Ops are register, derive, revoke
// and query by owner; the id of an entry is its index plus one.
// Result channel: each result is on the ports for one cycle with result_valid
// high; last marks the final result of an item. The receiver cannot stall, so
// nothing is held back. Query gives one result per unrevoked entry of the owner,
// in table order, or a single empty result; the other ops give one result.
// Sequencing:
//   register: busy for one cycle, in the dispatch state; the result is registered from it.
//   derive: on a missing parent the result is registered from the dispatch check, else
//     from the exec state, which follows the parent's rights and type read.
//   revoke, query: busy through dispatch and the scan; the final result is registered
//     as the scan finishes, which waits for the mark of a last entry that is an unrevoked
//     child. The scan reads one entry a cycle through a three-stage pipeline (entry read,
//     parent flag read, mark); query matches stream out during the scan.
// A new item may transfer while the previous final result is on the ports.
// Reset clears the fill count and the control state; table contents are not
// cleared and need no clearing pass, since only filled entries are read.
module capability_derivation_table
    import cdt_pkg::*;
    #(
        parameter int ENTRIES = 64
    )
    (
        input  logic                clk,
        input  logic                rst_n,
        input  logic                start,
        output logic                busy,
        input  logic [1:0]          op,
        input  logic [OWNER_W-1:0]  owner,
        input  logic [TYPE_W-1:0]   cap_type,
        input  logic [RIGHTS_W-1:0] rights,
        input  logic [ID_W-1:0]     target_id,
        output logic                result_valid,
        output logic [1:0]          status,
        output logic [ID_W-1:0]     cap_id,
        output logic [COUNT_W-1:0]  revoked_count,
        output logic                match_valid,
        output logic                last
    );

    cdt_cmd_t cmd;
    cdt_sts_t sts;

    cdt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    cdt_dp #(.ENTRIES(ENTRIES)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .owner         (owner),
        .cap_type      (cap_type),
        .rights        (rights),
        .target_id     (target_id),
        .result_valid  (result_valid),
        .status        (status),
        .cap_id        (cap_id),
        .revoked_count (revoked_count),
        .match_valid   (match_valid),
        .last          (last)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

import cdt_pkg::*;

class cap_table_scoreboard;
    localparam int DEPTH = 64;

    typedef struct {
        cdt_status_t        status;
        logic [ID_W-1:0]    cap_id;
        logic [COUNT_W-1:0] revoked_count;
        logic               match_valid;
        logic               last;
    } cap_result_t;

    cap_result_t expected_results[$];
    int unsigned fill_level;
    logic [ID_W-1:0]     parent_of[DEPTH];
    logic [OWNER_W-1:0]  holder_of[DEPTH];
    logic [TYPE_W-1:0]   kind_of[DEPTH];
    logic [RIGHTS_W-1:0] rights_of[DEPTH];
    bit                  revoked[DEPTH];
    int                  error_count;

    function new();
        fill_level  = 0;
        error_count = 0;
    endfunction

    function void push_result(cdt_status_t st, int unsigned id, int unsigned cnt, bit mv,
                              bit lst);
        cap_result_t r;
        r.status        = st;
        r.cap_id        = id[ID_W-1:0];
        r.revoked_count = cnt[COUNT_W-1:0];
        r.match_valid   = mv;
        r.last          = lst;
        expected_results.push_back(r);
    endfunction

    function int unsigned add_entry(logic [ID_W-1:0] parent, logic [OWNER_W-1:0] holder,
                                    logic [TYPE_W-1:0] kind, logic [RIGHTS_W-1:0] grant);
        int unsigned idx;
        idx            = fill_level;
        parent_of[idx] = parent;
        holder_of[idx] = holder;
        kind_of[idx]   = kind;
        rights_of[idx] = grant;
        revoked[idx]   = 1'b0;
        fill_level     = idx + 1;
        return idx + 1;
    endfunction

    function logic [RIGHTS_W-1:0] rights_at(logic [ID_W-1:0] target);
        if (target != 0 && target <= fill_level)
            return rights_of[target-1];
        return $urandom;
    endfunction

    // Work out the results of one accepted command and queue them.
    function void note_command(cdt_op_t cmd, logic [OWNER_W-1:0] holder,
                               logic [TYPE_W-1:0] kind, logic [RIGHTS_W-1:0] grant,
                               logic [ID_W-1:0] target);
        int unsigned pidx;
        int unsigned marks;
        int unsigned hits;
        int unsigned p;
        cap_result_t tail;
        case (cmd)
            OP_REGISTER:
            begin
                if (fill_level >= DEPTH)
                    push_result(ST_FULL, 0, 0, 0, 1);
                else
                    push_result(ST_OK, add_entry(0, holder, kind, grant), 0, 0, 1);
            end
            OP_DERIVE:
            begin
                if (target == 0 || target > fill_level)
                    push_result(ST_NO_PARENT, 0, 0, 0, 1);
                else
                begin
                    pidx = target - 1;
                    if ((grant & rights_of[pidx]) != grant)
                        push_result(ST_ESCALATE, 0, 0, 0, 1);
                    else if (fill_level >= DEPTH)
                        push_result(ST_FULL, 0, 0, 0, 1);
                    else
                        push_result(ST_OK, add_entry(target, holder, kind_of[pidx], grant),
                                    0, 0, 1);
                end
            end
            OP_REVOKE:
            begin
                marks = 0;
                if (target != 0 && target <= fill_level)
                begin
                    revoked[target-1] = 1'b1;
                    marks++;
                end
                // Parents sit at lower indexes, so one forward pass finishes the cascade.
                for (int i = 0; i < fill_level; i++)
                begin
                    p = parent_of[i];
                    if (!revoked[i] && p != 0 && p <= fill_level && revoked[p-1])
                    begin
                        revoked[i] = 1'b1;
                        marks++;
                    end
                end
                push_result(ST_OK, 0, marks, 0, 1);
            end
            default:
            begin
                hits = 0;
                for (int i = 0; i < fill_level; i++)
                begin
                    if (!revoked[i] && holder_of[i] == holder)
                    begin
                        push_result(ST_OK, i + 1, 0, 1, 0);
                        hits++;
                    end
                end
                if (hits == 0)
                    push_result(ST_OK, 0, 0, 0, 1);
                else
                begin
                    tail      = expected_results.pop_back();
                    tail.last = 1'b1;
                    expected_results.push_back(tail);
                end
            end
        endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    function void check_result(logic [1:0] st, logic [ID_W-1:0] id, logic [COUNT_W-1:0] cnt,
                               logic mv, logic lst);
        cap_result_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual status=%0d cap_id=%0d",
                     $time, st, id);
            error_count++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("status", want.status, st);
        compare_field("cap_id", want.cap_id, id);
        compare_field("revoked_count", want.revoked_count, cnt);
        compare_field("match_valid", want.match_valid, mv);
        compare_field("last", want.last, lst);
    endfunction
endclass

module tb;
    localparam int TABLE_DEPTH = 64;
    localparam int RANDOM_ITEMS = 320;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    cdt_op_t             op;
    logic [OWNER_W-1:0]  owner;
    logic [TYPE_W-1:0]   cap_type;
    logic [RIGHTS_W-1:0] rights;
    logic [ID_W-1:0]     target_id;
    logic                result_valid;
    logic [1:0]          status;
    logic [ID_W-1:0]     cap_id;
    logic [COUNT_W-1:0]  revoked_count;
    logic                match_valid;
    logic                last;

    cap_table_scoreboard ledger = new();

    capability_derivation_table #(.ENTRIES(TABLE_DEPTH)) u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .owner         (owner),
        .cap_type      (cap_type),
        .rights        (rights),
        .target_id     (target_id),
        .result_valid  (result_valid),
        .status        (status),
        .cap_id        (cap_id),
        .revoked_count (revoked_count),
        .match_valid   (match_valid),
        .last          (last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            ledger.check_result(status, cap_id, revoked_count, match_valid, last);
    end

    // Hold the command until it transfers, then note it.
    task automatic send_item(cdt_op_t kind, logic [OWNER_W-1:0] holder,
                             logic [TYPE_W-1:0] ctype, logic [RIGHTS_W-1:0] grant,
                             logic [ID_W-1:0] target);
        start     <= 1'b1;
        op        <= kind;
        owner     <= holder;
        cap_type  <= ctype;
        rights    <= grant;
        target_id <= target;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        ledger.note_command(kind, holder, ctype, grant, target);
    endtask

    task automatic pause(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (ledger.expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_item();
        int unsigned         pick;
        cdt_op_t             kind;
        logic [OWNER_W-1:0]  holder;
        logic [TYPE_W-1:0]   ctype;
        logic [RIGHTS_W-1:0] grant;
        logic [ID_W-1:0]     target;
        pick   = $urandom_range(0, 99);
        holder = ($urandom_range(0, 9) == 0) ? OWNER_W'($urandom)
                                             : OWNER_W'($urandom_range(0, 7));
        ctype  = TYPE_W'($urandom);
        grant  = $urandom;
        if ($urandom_range(0, 7) == 0 || ledger.fill_level == 0)
            target = ID_W'($urandom);
        else
            target = ID_W'($urandom_range(1, ledger.fill_level));
        if (pick < 25)
            kind = OP_REGISTER;
        else if (pick < 55)
        begin
            kind = OP_DERIVE;
            // Mostly narrow the parent's rights; leave some to escalate.
            if ($urandom_range(0, 4) != 0)
                grant = ledger.rights_at(target) & ($urandom_range(0, 3) == 0 ? '1 : $urandom);
        end
        else if (pick < 70)
            kind = OP_REVOKE;
        else
            kind = OP_QUERY;
        send_item(kind, holder, ctype, grant, target);
    endtask

    initial
    begin
        int unsigned   sent;
        int unsigned   burst;
        logic [ID_W-1:0] narrow_id;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        op        <= OP_REGISTER;
        owner     <= '0;
        cap_type  <= '0;
        rights    <= '0;
        target_id <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        send_item(OP_QUERY, 16'h0000, 4'h0, 32'h0, 7'd0);
        send_item(OP_REVOKE, 16'h0000, 4'h0, 32'h0, 7'd0);
        send_item(OP_DERIVE, 16'h0001, 4'h0, 32'h0, 7'd0);
        send_item(OP_DERIVE, 16'h0001, 4'h0, 32'h0, 7'd1);
        // field extremes
        send_item(OP_REGISTER, 16'hFFFF, 4'hF, 32'hFFFF_FFFF, 7'h7F);
        send_item(OP_REGISTER, 16'h0000, 4'h0, 32'h0000_0000, 7'h00);
        send_item(OP_DERIVE, 16'h0005, 4'h9, 32'h0F0F_0F0F, 7'd1);
        send_item(OP_DERIVE, 16'h0005, 4'h0, 32'h0000_0001, 7'd2);
        send_item(OP_DERIVE, 16'h0005, 4'h0, 32'hFFFF_FFFF, 7'd3);
        send_item(OP_DERIVE, 16'h0005, 4'h0, 32'h0, 7'h7F);
        send_item(OP_QUERY, 16'hFFFF, 4'h0, 32'h0, 7'd0);
        send_item(OP_REVOKE, 16'h0000, 4'h0, 32'h0, 7'd1);
        // child of a revoked parent starts live, then an unknown-target revoke sweeps it
        send_item(OP_DERIVE, 16'h0005, 4'h3, 32'h0000_0001, 7'd1);
        send_item(OP_QUERY, 16'h0005, 4'h0, 32'h0, 7'd0);
        send_item(OP_REVOKE, 16'h0000, 4'h0, 32'h0, 7'd0);
        send_item(OP_REVOKE, 16'h0000, 4'h0, 32'h0, 7'd100);
        send_item(OP_REVOKE, 16'h0000, 4'h0, 32'h0, 7'd1);
        send_item(OP_QUERY, 16'h0005, 4'h0, 32'h0, 7'd0);
        send_item(OP_QUERY, 16'h0000, 4'h0, 32'h0, 7'd0);
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                random_item();
                sent++;
                if (sent == RANDOM_ITEMS / 2)
                    drain();
            end
            if ($urandom_range(0, 3) != 0)
                pause(($urandom_range(0, 3) == 0) ? $urandom_range(7, 80) : $urandom_range(1, 6));
        end

        // fill the table, then hit every check with no room left
        while (ledger.fill_level < TABLE_DEPTH)
            send_item(OP_REGISTER, OWNER_W'($urandom_range(0, 7)), TYPE_W'($urandom), $urandom,
                      7'd0);
        narrow_id = 7'd1;
        for (int i = 1; i <= TABLE_DEPTH; i++)
        begin
            if (ledger.rights_at(ID_W'(i)) != '1)
                narrow_id = ID_W'(i);
        end
        send_item(OP_REGISTER, 16'h0001, 4'h1, 32'h1, 7'd0);
        send_item(OP_DERIVE, 16'h0001, 4'h1, 32'h0, 7'd64);
        send_item(OP_DERIVE, 16'h0001, 4'h1, 32'h0, 7'd65);
        send_item(OP_DERIVE, 16'h0001, 4'h1, 32'hFFFF_FFFF, narrow_id);
        send_item(OP_QUERY, 16'h0003, 4'h0, 32'h0, 7'd0);
        send_item(OP_REVOKE, 16'h0000, 4'h0, 32'h0, 7'd64);
        send_item(OP_REVOKE, 16'h0000, 4'h0, 32'h0, 7'd0);
        send_item(OP_QUERY, 16'h0002, 4'h0, 32'h0, 7'd0);

        drain();
        repeat (72) @(posedge clk);
        if (ledger.error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
